// ----- hw/rtl/uvs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV sphere vertex generator - shared package
// Widths, register codes, stage counts and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package uvs_pkg;

	// register file
	localparam int SEG_W      = 8;
	localparam int DEN_W      = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int RGB_W      = 24;

	localparam logic [SEG_W-1:0] MIN_SEGMENTS = 8'd3;
	localparam logic [SEG_W-1:0] MAX_SEGMENTS = 8'd255;
	localparam logic [SEG_W-1:0] SEG_RESET    = 8'd16;
	localparam logic [RGB_W-1:0] TOP_RESET    = 24'hFFFFFF;
	localparam logic [RGB_W-1:0] MID_RESET    = 24'h808080;
	localparam logic [RGB_W-1:0] BOT_RESET    = 24'h000000;

	localparam logic [CFG_IDX_W-1:0] CFG_LAT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LON = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MID = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BOT = 3'd4;

	// divider: restoring, several quotient bits per stage
	localparam int DIV_W      = 32;
	localparam int DIV_STEPS  = 8;
	localparam int DIV_STAGES = DIV_W / DIV_STEPS;

	// sine/cosine unit
	localparam int ANG_W         = 24;
	localparam int CW            = 34;
	localparam int COR_ITERS     = 24;
	localparam int COR_PER_STAGE = 2;
	localparam int COR_LOOP      = COR_ITERS / COR_PER_STAGE;
	localparam int COR_STAGES    = COR_LOOP + 3;

	localparam logic [15:0] RAD_LO = 16'd46405;
	localparam logic [16:0] RAD_HI = 17'd102943;
	localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;
	localparam logic signed [CW-1:0] Q30_ONE  = 34'sd1073741824;

	// position scaling
	localparam int POS_STAGES = 3;
	localparam int POS_LIMIT  = 16384;

	localparam int PIPE_DEPTH = 1 + DIV_STAGES + COR_STAGES + POS_STAGES;

	// per-word side data
	typedef struct packed {
		logic        pv;
		logic        qc;
		logic [15:0] vnum;
		logic [15:0] rowb;
	} meta_t;

	typedef struct packed {
		logic [16:0]      tex_u;
		logic [16:0]      tex_v;
		logic [RGB_W-1:0] rgb;
	} post_t;

	// arctangent of 2^-i in Q30
	function automatic logic signed [CW-1:0] atan_q30(input int i);
		case (i)
			0:       return 34'sd843314857;
			1:       return 34'sd497837829;
			2:       return 34'sd263043837;
			3:       return 34'sd133525159;
			4:       return 34'sd67021687;
			5:       return 34'sd33543516;
			6:       return 34'sd16775851;
			7:       return 34'sd8388437;
			8:       return 34'sd4194283;
			9:       return 34'sd2097149;
			10:      return 34'sd1048576;
			11:      return 34'sd524288;
			12:      return 34'sd262144;
			13:      return 34'sd131072;
			14:      return 34'sd65536;
			15:      return 34'sd32768;
			16:      return 34'sd16384;
			17:      return 34'sd8192;
			18:      return 34'sd4096;
			19:      return 34'sd2048;
			20:      return 34'sd1024;
			21:      return 34'sd512;
			22:      return 34'sd256;
			23:      return 34'sd128;
			default: return 34'sd0;
		endcase
	endfunction

endpackage

// ----- hw/rtl/uvs_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV sphere vertex generator - stream interfaces
// Grid point request channel and vertex result channel, valid/ready.
// ----------------------------------------------------------------------------
interface uvs_grid_if;
	logic       valid;
	logic       ready;
	logic [7:0] row_index;
	logic [7:0] col_index;

	modport source (output valid, row_index, col_index, input ready);
	modport sink   (input valid, row_index, col_index, output ready);
endinterface

interface uvs_vertex_if;
	logic               valid;
	logic               ready;
	logic               point_valid;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [15:0] pos_z;
	logic [23:0]        blend_rgb;
	logic [16:0]        tex_u;
	logic [16:0]        tex_v;
	logic [15:0]        vertex_number;
	logic [15:0]        row_below_number;
	logic               quad_corner;

	modport source (output valid, point_valid, pos_x, pos_y, pos_z, blend_rgb,
		tex_u, tex_v, vertex_number, row_below_number, quad_corner, input ready);
	modport sink   (input valid, point_valid, pos_x, pos_y, pos_z, blend_rgb,
		tex_u, tex_v, vertex_number, row_below_number, quad_corner, output ready);
endinterface

// ----- hw/rtl/uvs_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, 32-bit numerator by 9-bit divisor, 8 quotient bits per
// stage. The user keeps the divisor steady while words fly; not enforced.
// ----------------------------------------------------------------------------
module uvs_div
	import uvs_pkg::*;
(
	input  logic                  clk,
	input  logic [DIV_STAGES-1:0] en,
	input  logic [DIV_W-1:0]      num,
	input  logic [DEN_W-1:0]      den,
	output logic [DIV_W-1:0]      quo
);

	// partial remainder and numerator/quotient shift word per stage
	logic [DEN_W-1:0] rem_s [DIV_STAGES];
	logic [DIV_W-1:0] nq_s  [DIV_STAGES];

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic [DEN_W-1:0] rem_in;
		logic [DIV_W-1:0] nq_in;
		logic [DEN_W-1:0] rem_nx;
		logic [DIV_W-1:0] nq_nx;

		if (g == 0) begin : g_first
			assign rem_in = '0;
			assign nq_in  = num;
		end else begin : g_next
			assign rem_in = rem_s[g-1];
			assign nq_in  = nq_s[g-1];
		end

		// per step: shift in one numerator bit, subtract when it fits
		always_comb begin
			logic [DEN_W:0] trial;
			rem_nx = rem_in;
			nq_nx  = nq_in;
			trial  = '0;
			for (int k = 0; k < DIV_STEPS; k++) begin
				trial = {rem_nx, nq_nx[DIV_W-1]};
				nq_nx = {nq_nx[DIV_W-2:0], 1'b0};
				if (trial >= {1'b0, den}) begin
					trial    = trial - {1'b0, den};
					nq_nx[0] = 1'b1;
				end
				rem_nx = trial[DEN_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en[g]) begin
				rem_s[g] <= rem_nx;
				nq_s[g]  <= nq_nx;
			end
		end
	end

	assign quo = nq_s[DIV_STAGES-1];

endmodule

// ----- hw/rtl/uvs_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined sine/cosine of a binary angle
// 2^24 per turn. Quadrant split, radian scaling, 24 CORDIC rotations two per
// stage, then quadrant fold. Results in Q30.
// ----------------------------------------------------------------------------
module uvs_cordic
	import uvs_pkg::*;
(
	input  logic                   clk,
	input  logic [COR_STAGES-1:0]  en,
	input  logic [ANG_W-1:0]       angle,
	output logic signed [CW-1:0]   co,
	output logic signed [CW-1:0]   si
);

	localparam int R_W   = ANG_W - 2;
	localparam int PLO_W = R_W + 16;
	localparam int PHI_W = R_W + 17;
	localparam int SUM_W = PHI_W + 17;
	localparam logic [SUM_W-1:0] RAD_ROUND = SUM_W'(1) << 23;

	// quadrant (2 bits) and zero-remainder flag travel alongside
	logic [2:0] qz_s [COR_STAGES-1];

	logic [PLO_W-1:0] plo_s1;
	logic [PHI_W-1:0] phi_s1;
	logic signed [CW-1:0] z_s2;
	logic [SUM_W-1:0] zsum;

	logic signed [CW-1:0] x_s [COR_LOOP];
	logic signed [CW-1:0] y_s [COR_LOOP];
	logic signed [CW-1:0] z_s [COR_LOOP];

	// radian scaling, constant split in two partial products
	always_ff @(posedge clk) begin
		if (en[0]) begin
			plo_s1   <= PLO_W'(angle[R_W-1:0]) * PLO_W'(RAD_LO);
			phi_s1   <= PHI_W'(angle[R_W-1:0]) * PHI_W'(RAD_HI);
			qz_s[0]  <= {angle[ANG_W-1:R_W], angle[R_W-1:0] == '0};
		end
	end

	assign zsum = SUM_W'({phi_s1, 16'b0}) + SUM_W'(plo_s1) + RAD_ROUND;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			z_s2 <= $signed({3'b000, zsum[SUM_W-2:24]});
		end
	end

	// side flags down the pipe
	always_ff @(posedge clk) begin
		for (int k = 1; k < COR_STAGES - 1; k++) begin
			if (en[k]) qz_s[k] <= qz_s[k-1];
		end
	end

	// rotation stages
	for (genvar g = 0; g < COR_LOOP; g++) begin : g_rot
		logic signed [CW-1:0] x_in, y_in, z_in;
		logic signed [CW-1:0] x_nx, y_nx, z_nx;

		if (g == 0) begin : g_first
			assign x_in = CORDIC_K;
			assign y_in = '0;
			assign z_in = z_s2;
		end else begin : g_next
			assign x_in = x_s[g-1];
			assign y_in = y_s[g-1];
			assign z_in = z_s[g-1];
		end

		always_comb begin
			logic signed [CW-1:0] dx;
			logic signed [CW-1:0] dy;
			x_nx = x_in;
			y_nx = y_in;
			z_nx = z_in;
			dx   = '0;
			dy   = '0;
			for (int k = 0; k < COR_PER_STAGE; k++) begin
				dx = y_nx >>> (g * COR_PER_STAGE + k);
				dy = x_nx >>> (g * COR_PER_STAGE + k);
				if (!z_nx[CW-1]) begin
					x_nx = x_nx - dx;
					y_nx = y_nx + dy;
					z_nx = z_nx - atan_q30(g * COR_PER_STAGE + k);
				end else begin
					x_nx = x_nx + dx;
					y_nx = y_nx - dy;
					z_nx = z_nx + atan_q30(g * COR_PER_STAGE + k);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[g+2]) begin
				x_s[g] <= x_nx;
				y_s[g] <= y_nx;
				z_s[g] <= z_nx;
			end
		end
	end

	// quadrant fold; a zero remainder is exactly cos 1, sin 0
	logic signed [CW-1:0] xf, yf, co_nx, si_nx;
	logic [2:0] qz_last;

	assign qz_last = qz_s[COR_STAGES-2];
	assign xf      = qz_last[0] ? Q30_ONE : x_s[COR_LOOP-1];
	assign yf      = qz_last[0] ? '0 : y_s[COR_LOOP-1];

	always_comb begin
		case (qz_last[2:1])
			2'd0: begin
				co_nx = xf;
				si_nx = yf;
			end
			2'd1: begin
				co_nx = -yf;
				si_nx = xf;
			end
			2'd2: begin
				co_nx = -xf;
				si_nx = -yf;
			end
			default: begin
				co_nx = yf;
				si_nx = -xf;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[COR_STAGES-1]) begin
			co <= co_nx;
			si <= si_nx;
		end
	end

endmodule

// ----- hw/rtl/uvs_pos.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Position scaling
// x = sin(theta)cos(phi), z = sin(theta)sin(phi), y = cos(theta), brought
// from Q30 to Q1.15 at half scale with round half away from zero and clamp.
// ----------------------------------------------------------------------------
module uvs_pos
	import uvs_pkg::*;
(
	input  logic                  clk,
	input  logic [POS_STAGES-1:0] en,
	input  logic signed [CW-1:0]  ct,
	input  logic signed [CW-1:0]  st,
	input  logic signed [CW-1:0]  cp,
	input  logic signed [CW-1:0]  sp,
	output logic signed [15:0]    px,
	output logic signed [15:0]    py,
	output logic signed [15:0]    pz
);

	localparam int PH_W = CW + 18;
	localparam int PL_W = CW + 17;
	localparam int PW   = 68;

	function automatic logic signed [15:0] round_clamp(input logic signed [PW-1:0] v,
		input int sh);
		logic [PW-1:0] mag;
		logic [PW-1:0] rnd;
		logic [15:0]   lim;
		mag = v[PW-1] ? PW'(-v) : PW'(v);
		rnd = (mag + (PW'(1) << (sh - 1))) >> sh;
		lim = (rnd > PW'(POS_LIMIT)) ? 16'(POS_LIMIT) : rnd[15:0];
		return v[PW-1] ? -$signed(lim) : $signed(lim);
	endfunction

	logic signed [17:0] cp_hi, sp_hi;
	logic signed [16:0] cp_lo, sp_lo;

	assign cp_hi = $signed(cp[CW-1:16]);
	assign sp_hi = $signed(sp[CW-1:16]);
	assign cp_lo = $signed({1'b0, cp[15:0]});
	assign sp_lo = $signed({1'b0, sp[15:0]});

	logic signed [PH_W-1:0] xh_s1, zh_s1;
	logic signed [PL_W-1:0] xl_s1, zl_s1;
	logic signed [CW-1:0]   ct_s1, ct_s2;
	logic signed [PW-1:0]   xp_s2, zp_s2;

	// partial products
	always_ff @(posedge clk) begin
		if (en[0]) begin
			xh_s1 <= PH_W'(st) * PH_W'(cp_hi);
			xl_s1 <= PL_W'(st) * PL_W'(cp_lo);
			zh_s1 <= PH_W'(st) * PH_W'(sp_hi);
			zl_s1 <= PL_W'(st) * PL_W'(sp_lo);
			ct_s1 <= ct;
		end
	end

	// recombine
	always_ff @(posedge clk) begin
		if (en[1]) begin
			xp_s2 <= (PW'(xh_s1) <<< 16) + PW'(xl_s1);
			zp_s2 <= (PW'(zh_s1) <<< 16) + PW'(zl_s1);
			ct_s2 <= ct_s1;
		end
	end

	// round and clamp
	always_ff @(posedge clk) begin
		if (en[2]) begin
			px <= round_clamp(xp_s2, 46);
			pz <= round_clamp(zp_s2, 46);
			py <= round_clamp(PW'(ct_s2), 16);
		end
	end

endmodule

// ----- hw/rtl/uv_sphere_vertex_gen.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV sphere vertex generator
// Grid point in, one vertex word out: position, texture, colour, indices.
// ----------------------------------------------------------------------------
// Usage:
//   grid   - request word: row_index, col_index; taken when valid && ready.
//   vertex - result word, one per request, in request order.
//   cfg_*  - register writes (segment counts, three colours); write only
//            while no word is in flight.
// 23 register stages lie between an accepted request and its vertex word.
// Throughput is one word per cycle while the receiver takes words: 1 input
// stage, 4 divider stages (8 quotient bits each), 15 sine/cosine stages
// (2 CORDIC rotations in each rotation stage) and 3 multiply/round stages,
// every stage with its own valid bit.
// When the receiver stalls, the last stage holds its word and the stages
// behind it keep filling until they meet; nothing is dropped or repeated.
// Reset clears the valid bits and loads the register defaults (16 bands
// each way, white/grey/black colours); no clearing pass is needed.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_gen
	import uvs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	uvs_grid_if.sink              grid,
	uvs_vertex_if.source          vertex
);

	localparam int POST_N = PIPE_DEPTH - 1 - DIV_STAGES;
	localparam int COR_AT = 1 + DIV_STAGES;
	localparam int POS_AT = COR_AT + COR_STAGES;

	function automatic logic [SEG_W-1:0] clamp_seg(input logic [SEG_W-1:0] v);
		if (v < MIN_SEGMENTS) return MIN_SEGMENTS;
		if (v > MAX_SEGMENTS) return MAX_SEGMENTS;
		return v;
	endfunction

	// register file
	logic [SEG_W-1:0] lat_q, lon_q;
	logic [RGB_W-1:0] top_q, mid_q, bot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_q <= SEG_RESET;
			lon_q <= SEG_RESET;
			top_q <= TOP_RESET;
			mid_q <= MID_RESET;
			bot_q <= BOT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LAT: lat_q <= clamp_seg(cfg_data[SEG_W-1:0]);
				CFG_LON: lon_q <= clamp_seg(cfg_data[SEG_W-1:0]);
				CFG_TOP: top_q <= cfg_data[RGB_W-1:0];
				CFG_MID: mid_q <= cfg_data[RGB_W-1:0];
				CFG_BOT: bot_q <= cfg_data[RGB_W-1:0];
				default: ;
			endcase
		end
	end

	// stage valids; a stage moves when some stage at or after it is free
	logic [PIPE_DEPTH-1:0] stage_valid_q;
	logic [PIPE_DEPTH-1:0] en;

	for (genvar g = 0; g < PIPE_DEPTH; g++) begin : g_en
		assign en[g] = vertex.ready | ~(&stage_valid_q[PIPE_DEPTH-1:g]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			if (en[0]) stage_valid_q[0] <= grid.valid;
			for (int k = 1; k < PIPE_DEPTH; k++) begin
				if (en[k]) stage_valid_q[k] <= stage_valid_q[k-1];
			end
		end
	end

	assign grid.ready = en[0];

	// input stage: grid checks, indices, dividends
	logic [DEN_W-1:0] lat9, lon9, lon1, row2, n9, w_a;
	logic             upper;
	logic [RGB_W-1:0] col_a, col_b;
	logic [17:0]      cnum [3];
	logic [16:0]      vprod;
	logic [15:0]      vnum;
	meta_t            meta_in;

	assign lat9  = {1'b0, lat_q};
	assign lon9  = {1'b0, lon_q};
	assign lon1  = lon9 + 9'd1;
	assign row2  = {grid.row_index, 1'b0};
	assign upper = row2 < lat9;
	assign n9    = upper ? row2 : row2 - lat9;
	assign w_a   = lat9 - n9;
	assign col_a = upper ? top_q : mid_q;
	assign col_b = upper ? mid_q : bot_q;

	// blend numerators per channel
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			cnum[c] = 18'(col_a[c*8 +: 8]) * 18'(w_a) + 18'(col_b[c*8 +: 8]) * 18'(n9)
				+ 18'(lat_q[SEG_W-1:1]);
		end
	end

	assign vprod = 17'(grid.row_index) * 17'(lon1) + 17'(grid.col_index);
	assign vnum  = vprod[15:0];

	always_comb begin
		meta_in.pv   = (grid.row_index <= lat_q) && (grid.col_index <= lon_q);
		meta_in.qc   = (grid.row_index < lat_q) && (grid.col_index < lon_q);
		meta_in.vnum = meta_in.pv ? vnum : '0;
		meta_in.rowb = meta_in.qc ? vnum + 16'(lon1) : '0;
	end

	logic [DIV_W-1:0] ntu_s1, ntv_s1, nth_s1, nph_s1;
	logic [DIV_W-1:0] ncol_s1 [3];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ntu_s1 <= DIV_W'({grid.col_index, 16'b0}) + DIV_W'(lon_q[SEG_W-1:1]);
			ntv_s1 <= DIV_W'({grid.row_index, 16'b0}) + DIV_W'(lat_q[SEG_W-1:1]);
			nth_s1 <= {grid.row_index, 24'b0} + DIV_W'(lat_q);
			nph_s1 <= {grid.col_index, 24'b0} + DIV_W'(lon_q[SEG_W-1:1]);
			for (int c = 0; c < 3; c++) ncol_s1[c] <= DIV_W'(cnum[c]);
		end
	end

	// dividers
	logic [DIV_W-1:0] q_tu, q_tv, q_th, q_ph;
	logic [DIV_W-1:0] q_col [3];

	uvs_div u_div_tu (.clk, .en(en[1 +: DIV_STAGES]), .num(ntu_s1), .den(lon9), .quo(q_tu));
	uvs_div u_div_tv (.clk, .en(en[1 +: DIV_STAGES]), .num(ntv_s1), .den(lat9), .quo(q_tv));
	uvs_div u_div_th (.clk, .en(en[1 +: DIV_STAGES]), .num(nth_s1),
		.den({lat_q, 1'b0}), .quo(q_th));
	uvs_div u_div_ph (.clk, .en(en[1 +: DIV_STAGES]), .num(nph_s1), .den(lon9), .quo(q_ph));

	for (genvar c = 0; c < 3; c++) begin : g_col
		uvs_div u_div_col (.clk, .en(en[1 +: DIV_STAGES]), .num(ncol_s1[c]), .den(lat9),
			.quo(q_col[c]));
	end

	// texture and colour, saturated to one byte per channel
	post_t post_in;

	always_comb begin
		post_in.tex_u = q_tu[16:0];
		post_in.tex_v = q_tv[16:0];
		for (int c = 0; c < 3; c++) begin
			post_in.rgb[c*8 +: 8] = (q_col[c][DIV_W-1:8] != '0) ? 8'hFF : q_col[c][7:0];
		end
	end

	// side data delay lines
	meta_t meta_s [PIPE_DEPTH];
	post_t post_s [POST_N];

	always_ff @(posedge clk) begin
		if (en[0]) meta_s[0] <= meta_in;
		for (int k = 1; k < PIPE_DEPTH; k++) begin
			if (en[k]) meta_s[k] <= meta_s[k-1];
		end
		if (en[COR_AT]) post_s[0] <= post_in;
		for (int k = 1; k < POST_N; k++) begin
			if (en[COR_AT + k]) post_s[k] <= post_s[k-1];
		end
	end

	// sine and cosine of both angles
	logic signed [CW-1:0] ct, st, cp, sp;

	uvs_cordic u_cor_th (
		.clk,
		.en    (en[COR_AT +: COR_STAGES]),
		.angle (q_th[ANG_W-1:0]),
		.co    (ct),
		.si    (st)
	);

	uvs_cordic u_cor_ph (
		.clk,
		.en    (en[COR_AT +: COR_STAGES]),
		.angle (q_ph[ANG_W-1:0]),
		.co    (cp),
		.si    (sp)
	);

	logic signed [15:0] px, py, pz;

	uvs_pos u_pos (
		.clk,
		.en (en[POS_AT +: POS_STAGES]),
		.ct,
		.st,
		.cp,
		.sp,
		.px,
		.py,
		.pz
	);

	// result word; fields cleared outside the grid
	meta_t meta_out;
	post_t post_out;

	assign meta_out = meta_s[PIPE_DEPTH-1];
	assign post_out = post_s[POST_N-1];

	assign vertex.valid            = stage_valid_q[PIPE_DEPTH-1];
	assign vertex.point_valid      = meta_out.pv;
	assign vertex.pos_x            = meta_out.pv ? px : '0;
	assign vertex.pos_y            = meta_out.pv ? py : '0;
	assign vertex.pos_z            = meta_out.pv ? pz : '0;
	assign vertex.blend_rgb        = meta_out.pv ? post_out.rgb : '0;
	assign vertex.tex_u            = meta_out.pv ? post_out.tex_u : '0;
	assign vertex.tex_v            = meta_out.pv ? post_out.tex_v : '0;
	assign vertex.vertex_number    = meta_out.vnum;
	assign vertex.row_below_number = meta_out.rowb;
	assign vertex.quad_corner      = meta_out.qc;

endmodule

// ----- hw/rtl/uvs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV sphere vertex generator - port checker
// Watches the result channel of the top level; bound in below.
// ----------------------------------------------------------------------------
module uvs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               point_valid,
	input logic signed [15:0] pos_x,
	input logic signed [15:0] pos_y,
	input logic signed [15:0] pos_z,
	input logic [23:0]        blend_rgb,
	input logic [16:0]        tex_u,
	input logic [15:0]        vertex_number,
	input logic [15:0]        row_below_number,
	input logic               quad_corner
);

	// a stalled word stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// off-grid words carry zero position, colour, tex_u and vertex number
	a_off_grid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !point_valid |-> pos_x == 16'sd0 && pos_y == 16'sd0 &&
		pos_z == 16'sd0 && blend_rgb == 24'd0 && tex_u == 17'd0 && vertex_number == 16'd0)
		else $error("off-grid word has non-zero fields");

	// lower row index only on quad corners
	a_no_quad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !quad_corner |-> row_below_number == 16'd0)
		else $error("row below index without quad corner");

	a_quad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && quad_corner |-> point_valid && row_below_number > vertex_number)
		else $error("quad corner inconsistent with indices");

	// positions stay within the half-scale range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pos_x >= -16'sd16384 && pos_x <= 16'sd16384 &&
		pos_y >= -16'sd16384 && pos_y <= 16'sd16384 &&
		pos_z >= -16'sd16384 && pos_z <= 16'sd16384)
		else $error("position out of range");

endmodule

bind uv_sphere_vertex_gen uvs_checker u_uvs_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (vertex.valid),
	.out_ready        (vertex.ready),
	.point_valid      (vertex.point_valid),
	.pos_x            (vertex.pos_x),
	.pos_y            (vertex.pos_y),
	.pos_z            (vertex.pos_z),
	.blend_rgb        (vertex.blend_rgb),
	.tex_u            (vertex.tex_u),
	.vertex_number    (vertex.vertex_number),
	.row_below_number (vertex.row_below_number),
	.quad_corner      (vertex.quad_corner)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV sphere vertex generator - testbench
// Sends grid points under several band and colour settings, predicts each
// vertex word in the bench and checks every field in order, with random
// gaps on both sides, a long receiver hold-off and drain pauses.
// ----------------------------------------------------------------------------
module tb_top;
	import uvs_pkg::*;

	typedef struct {
		logic               pv;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] pz;
		logic [23:0]        rgb;
		logic [16:0]        tu;
		logic [16:0]        tv;
		logic [15:0]        vnum;
		logic [15:0]        rowb;
		logic               qc;
	} vertex_t;

	localparam longint TWO_PI_Q30 = 64'd6746518853;
	localparam int     IDLE_LIMIT = 5000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	uvs_grid_if   grid ();
	uvs_vertex_if vertex ();

	uv_sphere_vertex_gen dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.grid      (grid),
		.vertex    (vertex)
	);

	// bench copy of the register file
	int unsigned lat_bands, lon_bands;
	logic [23:0] top_rgb, mid_rgb, bot_rgb;

	vertex_t vertex_queue[$];
	int      errors;
	bit      gapless;
	bit      hold_req;
	int      idle_cycles;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// ---------------------------------------------------------------- predictor
	function automatic longint floor_sh(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_sh(longint v, int s);
		longint half;
		half = longint'(1) << (s - 1);
		if (v >= 0)
			return (v + half) >>> s;
		return -(((-v) + half) >>> s);
	endfunction

	function automatic longint clamp_pos(longint v);
		if (v > POS_LIMIT)
			return POS_LIMIT;
		if (v < -POS_LIMIT)
			return -POS_LIMIT;
		return v;
	endfunction

	// binary angle, 2^24 per turn, to cos/sin in Q30
	task automatic turn_sincos(input longint ang, output longint co, output longint si);
		longint a, r, x, y, z, dx, dy;
		int quad;
		a    = ang & 64'hFFFFFF;
		quad = int'(a >> 22);
		r    = a & 64'h3FFFFF;
		x    = 64'd1073741824;
		y    = 0;
		if (r != 0) begin
			z = (r * TWO_PI_Q30 + (longint'(1) << 23)) >> 24;
			x = 64'd652032874;
			for (int i = 0; i < COR_ITERS; i++) begin
				dx = floor_sh(y, i);
				dy = floor_sh(x, i);
				if (z >= 0) begin
					x = x - dx;
					y = y + dy;
					z = z - longint'(atan_q30(i));
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + longint'(atan_q30(i));
				end
			end
		end
		case (quad)
			0: begin co = x;  si = y;  end
			1: begin co = -y; si = x;  end
			2: begin co = -x; si = -y; end
			default: begin co = y; si = -x; end
		endcase
	endtask

	function automatic logic [23:0] mix_rgb(logic [23:0] a, logic [23:0] b,
			int unsigned n, int unsigned d);
		logic [23:0] res;
		int unsigned ca, cb, c;
		res = '0;
		for (int sh = 0; sh < 24; sh += 8) begin
			ca = (a >> sh) & 8'hFF;
			cb = (b >> sh) & 8'hFF;
			c  = (ca * (d - n) + cb * n + d / 2) / d;
			if (c > 255)
				c = 255;
			res = res | (24'(c) << sh);
		end
		return res;
	endfunction

	task automatic predict_vertex(input int unsigned row, input int unsigned col,
			output vertex_t v);
		longint theta, phi, ct, st, cp, sp;
		int unsigned vn;
		v = '{default: '0};
		if (row > lat_bands || col > lon_bands)
			return;
		theta = (longint'(row) * (longint'(1) << 24) + lat_bands) / (2 * lat_bands);
		phi   = ((longint'(col) << 24) + lon_bands / 2) / lon_bands;
		turn_sincos(theta, ct, st);
		turn_sincos(phi, cp, sp);
		v.pv = 1'b1;
		v.px = 16'(clamp_pos(round_sh(st * cp, 46)));
		v.py = 16'(clamp_pos(round_sh(ct, 16)));
		v.pz = 16'(clamp_pos(round_sh(st * sp, 46)));
		if (2 * row < lat_bands)
			v.rgb = mix_rgb(top_rgb, mid_rgb, 2 * row, lat_bands);
		else
			v.rgb = mix_rgb(mid_rgb, bot_rgb, 2 * row - lat_bands, lat_bands);
		v.tu = 17'(((longint'(col) << 16) + lon_bands / 2) / lon_bands);
		v.tv = 17'(((longint'(row) << 16) + lat_bands / 2) / lat_bands);
		vn = row * (lon_bands + 1) + col;
		v.vnum = 16'(vn);
		if (row < lat_bands && col < lon_bands) begin
			v.rowb = 16'(vn + lon_bands + 1);
			v.qc   = 1'b1;
		end
	endtask

	// ---------------------------------------------------------------- driving
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
		int unsigned s;
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		s = data & 8'hFF;
		if (s < 3)
			s = 3;
		case (idx)
			CFG_LAT: lat_bands = s;
			CFG_LON: lon_bands = s;
			CFG_TOP: top_rgb = data;
			CFG_MID: mid_rgb = data;
			CFG_BOT: bot_rgb = data;
			default: ;
		endcase
	endtask

	task automatic cfg_done();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_bands(input logic [23:0] lat, input logic [23:0] lon);
		cfg_write(CFG_LAT, lat);
		cfg_write(CFG_LON, lon);
		cfg_done();
	endtask

	// one grid word; valid stays high into the next call when there is no gap
	task automatic send_point(input logic [7:0] row, input logic [7:0] col);
		int gap;
		vertex_t v;
		gap = gapless ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			grid.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		grid.valid     <= 1'b1;
		grid.row_index <= row;
		grid.col_index <= col;
		@(posedge clk);
		while (!grid.ready)
			@(posedge clk);
		predict_vertex(row, col, v);
		vertex_queue = {vertex_queue, v};
	endtask

	task automatic drain();
		grid.valid <= 1'b0;
		@(posedge clk);
		while (vertex_queue.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// mostly in-grid points, some just past the edge, a few anywhere
	task automatic send_random_point();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 80)
			send_point(8'($urandom_range(0, lat_bands)), 8'($urandom_range(0, lon_bands)));
		else if (sel < 90)
			send_point(8'($urandom_range(0, lat_bands + 2 > 255 ? 255 : lat_bands + 2)),
				8'($urandom_range(0, lon_bands + 2 > 255 ? 255 : lon_bands + 2)));
		else
			send_point(8'($urandom), 8'($urandom));
	endtask

	// ---------------------------------------------------------------- tests
	task automatic test_directed();
		// reset settings: poles, equator, edges, out of grid
		send_point(8'd0, 8'd0);
		send_point(8'd16, 8'd16);
		send_point(8'd8, 8'd4);
		send_point(8'd17, 8'd0);
		send_point(8'd0, 8'd17);
		send_point(8'd255, 8'd255);
		drain();
		// band writes below the minimum clamp, upper bits are dropped
		set_bands(24'd0, 24'd2);
		cfg_write(CFG_TOP, 24'h000000);
		cfg_write(CFG_MID, 24'hFFFFFF);
		cfg_write(CFG_BOT, 24'hFF00FF);
		cfg_write(3'd5, 24'h000010);
		cfg_write(3'd7, 24'hFFFFFF);
		cfg_done();
		send_point(8'd0, 8'd3);
		send_point(8'd1, 8'd1);
		send_point(8'd3, 8'd3);
		send_point(8'd2, 8'd2);
		send_point(8'd4, 8'd0);
		drain();
		set_bands(24'hFFFF01, 24'h0001FF);
		send_point(8'd255, 8'd255);
		send_point(8'd254, 8'd254);
		send_point(8'd128, 8'd0);
		send_point(8'd127, 8'd64);
		send_point(8'd0, 8'd191);
		send_point(8'd255, 8'd0);
		drain();
		set_bands(24'd3, 24'd255);
		send_point(8'd3, 8'd255);
		send_point(8'd1, 8'd170);
		send_point(8'd4, 8'd1);
		drain();
	endtask

	task automatic test_random_settings();
		for (int ph = 0; ph < 14; ph++) begin
			case (ph)
				0: set_bands(24'd3, 24'd3);
				1: set_bands(24'd255, 24'd255);
				2: set_bands(24'd255, 24'd3);
				default: set_bands(ph % 2 ? 24'($urandom_range(3, 24)) : 24'($urandom),
					ph % 2 ? 24'($urandom_range(3, 24)) : 24'($urandom));
			endcase
			cfg_write(CFG_TOP, ph == 0 ? 24'hFFFFFF : 24'($urandom));
			cfg_write(CFG_MID, ph == 1 ? 24'h000000 : 24'($urandom));
			cfg_write(CFG_BOT, ph == 0 ? 24'h000000 : 24'($urandom));
			cfg_done();
			gapless = (ph % 4 == 3);
			for (int i = 0; i < 95; i++)
				send_random_point();
			gapless = 1'b0;
			drain();
		end
	endtask

	// receiver holds off while words keep coming; input must stall
	task automatic test_backpressure();
		set_bands(24'd12, 24'd20);
		hold_req = 1'b1;
		gapless  = 1'b1;
		for (int i = 0; i < 70; i++)
			send_random_point();
		gapless = 1'b0;
		drain();
	endtask

	// ---------------------------------------------------------------- receiver
	initial begin
		int w;
		vertex.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				vertex.ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
			if (w > 0) begin
				vertex.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			vertex.ready <= 1'b1;
			@(posedge clk);
			while (!vertex.valid)
				@(posedge clk);
		end
	end

	// ---------------------------------------------------------------- checker
	task automatic report(input string field, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d", field, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		vertex_t e;
		if (arst_n && vertex.valid && vertex.ready) begin
			if (vertex_queue.size() == 0) begin
				$display("mismatch: vertex word with nothing expected");
				errors++;
			end else begin
				e = vertex_queue.pop_front();
				if (vertex.point_valid !== e.pv) report("point_valid", vertex.point_valid, e.pv);
				if (vertex.pos_x !== e.px) report("pos_x", vertex.pos_x, e.px);
				if (vertex.pos_y !== e.py) report("pos_y", vertex.pos_y, e.py);
				if (vertex.pos_z !== e.pz) report("pos_z", vertex.pos_z, e.pz);
				if (vertex.blend_rgb !== e.rgb) report("blend_rgb", vertex.blend_rgb, e.rgb);
				if (vertex.tex_u !== e.tu) report("tex_u", vertex.tex_u, e.tu);
				if (vertex.tex_v !== e.tv) report("tex_v", vertex.tex_v, e.tv);
				if (vertex.vertex_number !== e.vnum)
					report("vertex_number", vertex.vertex_number, e.vnum);
				if (vertex.row_below_number !== e.rowb)
					report("row_below_number", vertex.row_below_number, e.rowb);
				if (vertex.quad_corner !== e.qc) report("quad_corner", vertex.quad_corner, e.qc);
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if ((grid.valid && grid.ready) || (vertex.valid && vertex.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence
	initial begin
		errors         = 0;
		gapless        = 1'b0;
		hold_req       = 1'b0;
		lat_bands      = 16;
		lon_bands      = 16;
		top_rgb        = TOP_RESET;
		mid_rgb        = MID_RESET;
		bot_rgb        = BOT_RESET;
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_index      <= '0;
		cfg_data       <= '0;
		grid.valid     <= 1'b0;
		grid.row_index <= '0;
		grid.col_index <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_random_settings();
		test_backpressure();
		drain();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/uvs_pkg.sv
hw/rtl/uvs_if.sv
hw/rtl/uvs_div.sv
hw/rtl/uvs_cordic.sv
hw/rtl/uvs_pos.sv
hw/rtl/uv_sphere_vertex_gen.sv
hw/rtl/uvs_checker.sv
tb/tb_top.sv
